>>> design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// shared constants for the line box clipper: outcode bits, field width, limits
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

    localparam int FIELD_WIDTH       = 32;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int IN_FIELDS         = 8;
    localparam int OUT_COORDS        = 4;
    localparam int MAX_STEPS         = 8;
    localparam int STEP_WIDTH        = 4;

    localparam logic [3:0] CODE_LEFT   = 4'h1;
    localparam logic [3:0] CODE_RIGHT  = 4'h2;
    localparam logic [3:0] CODE_BOTTOM = 4'h4;
    localparam logic [3:0] CODE_TOP    = 4'h8;

endpackage

`default_nettype wire

>>> design/line_box_clipper_unit.sv
// ----------------------------------------------------------------------------
// line_box_clipper_unit
// cohen-sutherland clipping of one segment to an axis-aligned box per word
// ----------------------------------------------------------------------------
// sequence: each clip step runs the check, setup, multiply, bit-serial divide
//   and update states; after up to MAX_STEPS steps the final check registers
//   the result word and m_tvalid, with no clip step for a trivial case
// throughput: one word at a time, next accept once m_tready has taken the result
// reset: aresetn synchronous, active low; clears sequencer and output valid
`default_nettype none

module line_box_clipper_unit #(
    parameter int COORD_WIDTH = lbc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // box_left, box_bottom, box_right, box_top, start_x, start_y, end_x, end_y
    input  wire logic [lbc_pkg::IN_FIELDS*lbc_pkg::FIELD_WIDTH-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic [lbc_pkg::OUT_COORDS*lbc_pkg::FIELD_WIDTH-1:0] m_tdata,
    // crosses
    output logic      m_tuser
);
    import lbc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int CW  = $clog2(2*W+1);
    localparam int FW  = FIELD_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SETUP, ST_MUL, ST_DIV, ST_UPD, ST_OUT
    } state_t;

    state_t state_reg;

    // box and current endpoints
    logic signed [W-1:0] l_reg, b_reg, r_reg, t_reg;
    logic signed [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [STEP_WIDTH-1:0] step_reg;

    // interpolation operands
    logic [W-1:0]        ma_reg, mb_reg, md_reg;
    logic                neg_reg;
    logic                yaxis_reg;   // 1: solve for y on a vertical edge
    logic                first_reg;   // moving the start endpoint
    logic signed [W-1:0] base_reg, edge_reg;

    // divider
    logic [W-1:0]   rem_reg;
    logic [2*W-1:0] dq_reg;
    logic [CW-1:0]  cnt_reg;

    // output word
    logic [OUT_COORDS*FW-1:0] data_reg;
    logic                     user_reg;
    logic                     valid_reg;

    // outcode of a point against the box, edge points inside
    function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                           input logic signed [W-1:0] y,
                                           input logic signed [W-1:0] l,
                                           input logic signed [W-1:0] b,
                                           input logic signed [W-1:0] r,
                                           input logic signed [W-1:0] t);
        logic [3:0] c;
        c = 4'h0;
        if (x < l) c = CODE_LEFT;
        else if (x > r) c = CODE_RIGHT;
        if (y < b) c = c | CODE_BOTTOM;
        else if (y > t) c = c | CODE_TOP;
        return c;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W:0] d);
        logic signed [W:0] a;
        a = d[W] ? -d : d;
        return a[W-1:0];
    endfunction

    logic [3:0] c1, c2, cd;
    assign c1 = outcode(x1_reg, y1_reg, l_reg, b_reg, r_reg, t_reg);
    assign c2 = outcode(x2_reg, y2_reg, l_reg, b_reg, r_reg, t_reg);
    assign cd = (c1 != 4'h0) ? c1 : c2;

    // edge chosen for this step, checked left, right, bottom, top
    logic signed [W:0] dx, dy, da, db, dd;
    logic signed [W-1:0] edge_c, base_c;
    logic                yaxis_c;
    always_comb begin
        dx = $signed({x2_reg[W-1], x2_reg}) - $signed({x1_reg[W-1], x1_reg});
        dy = $signed({y2_reg[W-1], y2_reg}) - $signed({y1_reg[W-1], y1_reg});
        if ((cd & CODE_LEFT) != 4'h0) begin
            edge_c = l_reg; yaxis_c = 1'b1;
        end else if ((cd & CODE_RIGHT) != 4'h0) begin
            edge_c = r_reg; yaxis_c = 1'b1;
        end else if ((cd & CODE_BOTTOM) != 4'h0) begin
            edge_c = b_reg; yaxis_c = 1'b0;
        end else begin
            edge_c = t_reg; yaxis_c = 1'b0;
        end
        if (yaxis_c) begin
            da = dy; dd = dx; base_c = y1_reg;
            db = $signed({edge_c[W-1], edge_c}) - $signed({x1_reg[W-1], x1_reg});
        end else begin
            da = dx; dd = dy; base_c = x1_reg;
            db = $signed({edge_c[W-1], edge_c}) - $signed({y1_reg[W-1], y1_reg});
        end
    end

    // one restoring divide step
    logic [W:0] shifted, trial;
    logic       ge;
    always_comb begin
        shifted = {rem_reg, dq_reg[2*W-1]};
        trial   = shifted - {1'b0, md_reg};
        ge      = (shifted >= {1'b0, md_reg});
    end

    // quotient, forced to zero on a zero divisor
    logic [W-1:0] quot;
    logic [W-1:0] newval;
    assign quot   = (md_reg == '0) ? '0 : dq_reg[W-1:0];
    assign newval = neg_reg ? (base_reg - quot) : (base_reg + quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        l_reg    <= s_tdata[0*FW +: W];
                        b_reg    <= s_tdata[1*FW +: W];
                        r_reg    <= s_tdata[2*FW +: W];
                        t_reg    <= s_tdata[3*FW +: W];
                        x1_reg   <= s_tdata[4*FW +: W];
                        y1_reg   <= s_tdata[5*FW +: W];
                        x2_reg   <= s_tdata[6*FW +: W];
                        y2_reg   <= s_tdata[7*FW +: W];
                        step_reg <= '0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if ((c1 | c2) == 4'h0) begin
                        user_reg  <= 1'b1;
                        data_reg  <= {FW'(y2_reg), FW'(x2_reg), FW'(y1_reg), FW'(x1_reg)};
                        valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if (((c1 & c2) != 4'h0) ||
                                 (step_reg == STEP_WIDTH'(MAX_STEPS))) begin
                        user_reg  <= 1'b0;
                        data_reg  <= '0;
                        valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    ma_reg    <= mag(da);
                    mb_reg    <= mag(db);
                    md_reg    <= mag(dd);
                    neg_reg   <= da[W] ^ db[W] ^ dd[W];
                    yaxis_reg <= yaxis_c;
                    first_reg <= (c1 != 4'h0);
                    base_reg  <= base_c;
                    edge_reg  <= edge_c;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    dq_reg    <= ma_reg * mb_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= ge ? trial[W-1:0] : shifted[W-1:0];
                    dq_reg  <= {dq_reg[2*W-2:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(2*W-1)) state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (first_reg) begin
                        x1_reg <= yaxis_reg ? edge_reg : newval;
                        y1_reg <= yaxis_reg ? newval : edge_reg;
                    end else begin
                        x2_reg <= yaxis_reg ? edge_reg : newval;
                        y2_reg <= yaxis_reg ? newval : edge_reg;
                    end
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= ST_CHECK;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

>>> design/lbc_checker.sv
// ----------------------------------------------------------------------------
// lbc_checker
// port-level checks of the line box clipper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [lbc_pkg::OUT_COORDS*lbc_pkg::FIELD_WIDTH-1:0] m_tdata,
    input wire logic m_tuser
);
    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // no crossing gives all-zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-crossing word carries coordinates");

    // one word in flight: no accept while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // after an accept the block is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("block not busy after accept");

endmodule

bind line_box_clipper_unit lbc_checker u_lbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
